FILE: rtl/acflru_pkg.sv
// shared constants, codes and types for the associative cache with fifo/lru replacement
package acflru_pkg;

    localparam int ENTRIES  = 128;
    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int KEY_BITS = 32;
    localparam int SIZE_W   = 32;
    localparam int STAMP_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 8;

    localparam int IN_W   = KEY_BITS + 1 + SIZE_W;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = 2 + SLOT_W + SIZE_W + 1;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    localparam logic [1:0] POLICY_FIFO = 2'd1;
    localparam logic [1:0] POLICY_LRU  = 2'd2;

    localparam logic CFG_POLICY  = 1'b0;
    localparam logic CFG_ENTRIES = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT        = 2'd0,
        ST_STORED     = 2'd1,
        ST_NOT_STORED = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DELIVER
    } ctrl_state_t;

    typedef struct packed {
        logic                active;
        logic                found;
        logic [SLOT_W-1:0]   hit_idx;
        logic [SIZE_W-1:0]   hit_size;
        logic                have_victim;
        logic                victim_empty;
        logic [SLOT_W-1:0]   victim;
        logic [STAMP_W-1:0]  best;
        logic [SLOT_W-1:0]   fifo_slot;
        logic                fifo_valid;
    } scan_tok_t;

    typedef struct packed {
        logic                en;
        logic                set_entry;
        logic                set_stamp;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_BITS-1:0] key;
        logic [SIZE_W-1:0]   size;
        logic [STAMP_W-1:0]  stamp;
    } wr_cmd_t;

    typedef struct packed {
        logic                evicted;
        logic [SIZE_W-1:0]   size_out;
        logic [SLOT_W-1:0]   slot;
        status_t             status;
    } result_t;

endpackage

FILE: rtl/acflru_cell.sv
// one table slot: holds its entry and updates the scan transaction passing down the row
module acflru_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [acflru_pkg::SLOT_W-1:0]   cell_idx,
    input  logic [acflru_pkg::COUNT_W-1:0]  slots_used,
    input  logic [acflru_pkg::KEY_BITS-1:0] req_key,
    input  acflru_pkg::wr_cmd_t             wr_cmd,
    input  acflru_pkg::scan_tok_t           tok_in,
    output acflru_pkg::scan_tok_t           tok_out
);
    import acflru_pkg::*;

    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    scan_tok_t           tok_reg;
    scan_tok_t           tok_next;
    logic                in_use;
    logic                wr_hit;

    assign in_use = tok_in.active && (COUNT_W'(cell_idx) < slots_used);
    assign wr_hit = wr_cmd.en && (wr_cmd.slot == cell_idx);

    always_comb begin
        tok_next = tok_in;
        if (in_use) begin
            if (!valid_reg) begin
                tok_next.victim       = cell_idx;
                tok_next.victim_empty = 1'b1;
                tok_next.have_victim  = 1'b1;
            end else if (!tok_in.victim_empty &&
                         (!tok_in.have_victim || stamp_reg < tok_in.best)) begin
                tok_next.victim      = cell_idx;
                tok_next.best        = stamp_reg;
                tok_next.have_victim = 1'b1;
            end
            if (valid_reg && key_reg == req_key) begin
                tok_next.found    = 1'b1;
                tok_next.hit_idx  = cell_idx;
                tok_next.hit_size = size_reg;
            end
            if (tok_in.fifo_slot == cell_idx) begin
                tok_next.fifo_valid = valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (wr_hit && wr_cmd.set_entry) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit && wr_cmd.set_entry) begin
            key_reg  <= wr_cmd.key;
            size_reg <= wr_cmd.size;
        end
        if (wr_hit && wr_cmd.set_stamp) begin
            stamp_reg <= wr_cmd.stamp;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/assoc_cache_fifo_lru_replace_unit.sv
// top level: request control, replacement decision and the row of slot cells
// path from input transaction to m_tvalid: start token register, then the scan
// transaction registered in each slot cell down the row, then result and output registers
// one request in flight: a new one is taken only in idle, once the last result has moved to the output register
// reset: valid bits, fifo pointer and stamp counter cleared at once, policy lru,
// all slots in use; no clearing pass
module assoc_cache_fifo_lru_replace_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // key, loadable, item_size
    input  logic [acflru_pkg::IN_TW-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // status, slot, size_out, evicted
    output logic [acflru_pkg::OUT_TW-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [acflru_pkg::CFG_W-1:0]  cfg_data
);
    import acflru_pkg::*;

    ctrl_state_t         state_reg, state_next;
    logic [1:0]          policy_reg;
    logic [COUNT_W-1:0]  entries_reg;
    logic [COUNT_W-1:0]  slots_used;
    logic [SLOT_W-1:0]   fifo_ptr_reg, fifo_ptr_next;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [KEY_BITS-1:0] req_key_reg;
    logic                req_load_reg;
    logic [SIZE_W-1:0]   req_size_reg;
    scan_tok_t           start_tok_reg;
    scan_tok_t           tok [ENTRIES+1];
    scan_tok_t           tok_end;
    wr_cmd_t             wr_cmd;
    result_t             res_reg, res_next;
    result_t             m_res_reg;
    logic                m_valid_reg;
    logic                in_fire;
    logic                res_load;
    logic                out_load;
    logic [SLOT_W-1:0]   fifo_slot;
    logic [SLOT_W:0]     fifo_inc;

    always_comb begin
        if (entries_reg == '0) begin
            slots_used = COUNT_W'(1);
        end else if (entries_reg > COUNT_W'(ENTRIES)) begin
            slots_used = COUNT_W'(ENTRIES);
        end else begin
            slots_used = entries_reg;
        end
    end

    assign in_fire   = s_tvalid && s_tready;
    assign fifo_slot = (COUNT_W'(fifo_ptr_reg) < slots_used) ? fifo_ptr_reg : '0;

    assign tok[0]  = start_tok_reg;
    assign tok_end = tok[ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        acflru_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (SLOT_W'(i)),
            .slots_used (slots_used),
            .req_key    (req_key_reg),
            .wr_cmd     (wr_cmd),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        res_load      = 1'b0;
        out_load      = 1'b0;
        res_next      = res_reg;
        fifo_ptr_next = fifo_ptr_reg;
        wr_cmd        = '0;
        wr_cmd.key    = req_key_reg;
        wr_cmd.size   = req_size_reg;
        wr_cmd.stamp  = stamp_reg;
        fifo_inc      = {1'b0, tok_end.fifo_slot} + 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok_end.active) begin
                    res_load         = 1'b1;
                    state_next       = S_DELIVER;
                    res_next         = '0;
                    if (tok_end.found) begin
                        res_next.status   = ST_HIT;
                        res_next.slot     = tok_end.hit_idx;
                        res_next.size_out = tok_end.hit_size;
                        wr_cmd.en         = 1'b1;
                        wr_cmd.set_stamp  = 1'b1;
                        wr_cmd.slot       = tok_end.hit_idx;
                    end else if (!req_load_reg) begin
                        res_next.status = ST_NOT_FOUND;
                    end else if (policy_reg == POLICY_FIFO) begin
                        res_next.status   = ST_STORED;
                        res_next.slot     = tok_end.fifo_slot;
                        res_next.size_out = req_size_reg;
                        res_next.evicted  = tok_end.fifo_valid;
                        wr_cmd.en         = 1'b1;
                        wr_cmd.set_entry  = 1'b1;
                        wr_cmd.slot       = tok_end.fifo_slot;
                        if (COUNT_W'(fifo_inc) == slots_used) begin
                            fifo_ptr_next = '0;
                        end else begin
                            fifo_ptr_next = fifo_inc[SLOT_W-1:0];
                        end
                    end else if (policy_reg == POLICY_LRU) begin
                        res_next.status   = ST_STORED;
                        res_next.slot     = tok_end.victim;
                        res_next.size_out = req_size_reg;
                        res_next.evicted  = !tok_end.victim_empty;
                        wr_cmd.en         = 1'b1;
                        wr_cmd.set_entry  = 1'b1;
                        wr_cmd.set_stamp  = 1'b1;
                        wr_cmd.slot       = tok_end.victim;
                    end else begin
                        res_next.status   = ST_NOT_STORED;
                        res_next.size_out = req_size_reg;
                    end
                end
            end
            S_DELIVER: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            policy_reg    <= POLICY_LRU;
            entries_reg   <= COUNT_W'(ENTRIES);
            fifo_ptr_reg  <= '0;
            stamp_reg     <= '0;
            start_tok_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fifo_ptr_reg <= fifo_ptr_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_POLICY:  policy_reg  <= cfg_data[1:0];
                    CFG_ENTRIES: entries_reg <= cfg_data[COUNT_W-1:0];
                    default:     policy_reg  <= policy_reg;
                endcase
            end
            start_tok_reg <= '0;
            if (in_fire) begin
                stamp_reg               <= stamp_reg + 1'b1;
                start_tok_reg.active    <= 1'b1;
                start_tok_reg.fifo_slot <= fifo_slot;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_key_reg  <= s_tdata[KEY_BITS-1:0];
            req_load_reg <= s_tdata[KEY_BITS];
            req_size_reg <= s_tdata[KEY_BITS+1 +: SIZE_W];
        end
        if (res_load) begin
            res_reg <= res_next;
        end
        if (out_load) begin
            m_res_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TW-OUT_W){1'b0}}, m_res_reg.evicted, m_res_reg.size_out,
                       m_res_reg.slot, m_res_reg.status};

endmodule
